FILE: rtl/ucte_pkg.sv
package ucte_pkg;

  // class codes
  localparam logic [2:0] CL_ALPHA = 3'd0;
  localparam logic [2:0] CL_DIGIT = 3'd1;
  localparam logic [2:0] CL_SPACE = 3'd2;
  localparam logic [2:0] CL_NL    = 3'd3;
  localparam logic [2:0] CL_PUNCT = 3'd4;
  localparam logic [2:0] CL_CJK   = 3'd5;
  localparam logic [2:0] CL_EMOJI = 3'd6;
  localparam logic [2:0] CL_OTHER = 3'd7;

  localparam int NUM_CLASSES = 8;
  localparam int CNT_W       = 21;
  localparam int CNT_MAX     = 2097151;
  localparam int MAX_MESSAGE_BYTES_DEF = 1048576;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT   = 2'd2;

  localparam int QDEPTH = 4;

  // reciprocals, floor(2^32 / rate)
  localparam logic [31:0] RECIP_35  = 32'((64'd1 << 32) / 35);
  localparam logic [31:0] RECIP_28  = 32'((64'd1 << 32) / 28);
  localparam logic [31:0] RECIP_50  = 32'((64'd1 << 32) / 50);
  localparam logic [31:0] RECIP_20  = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RECIP_25  = 32'((64'd1 << 32) / 25);
  localparam logic [31:0] RECIP_13  = 32'((64'd1 << 32) / 13);
  localparam logic [31:0] RECIP_10  = 32'((64'd1 << 32) / 10);
  localparam logic [31:0] RECIP_4   = 32'((64'd1 << 32) / 4);
  localparam logic [31:0] RECIP_12  = 32'((64'd1 << 32) / 12);
  localparam logic [31:0] RECIP_100 = 32'((64'd1 << 32) / 100);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       end_of_conversation;
  } in_t;

  typedef struct packed {
    logic [20:0] message_tokens;
    logic [31:0] running_total;
    logic        compact_needed;
    logic        conversation_done;
  } out_t;

  // one decoded request handed from front to back
  typedef struct packed {
    logic [2:0] oth_add;
    logic       cls_en;
    logic [2:0] cls;
    logic       eom;
    logic       eoc;
  } ev_t;

  // rate per step: classes 0..7, then the threshold step
  function automatic logic [6:0] rate_of(input logic [3:0] idx, input logic mode);
    logic [6:0] r;
    unique case (idx)
      4'd0: r = 7'd35;
      4'd1: r = 7'd28;
      4'd2: r = 7'd50;
      4'd3: r = 7'd20;
      4'd4: r = 7'd25;
      4'd5: r = mode ? 7'd20 : 7'd13;
      4'd6: r = mode ? 7'd10 : 7'd4;
      4'd7: r = 7'd12;
      default: r = 7'd100;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] recip_of(input logic [3:0] idx, input logic mode);
    logic [31:0] r;
    unique case (idx)
      4'd0: r = RECIP_35;
      4'd1: r = RECIP_28;
      4'd2: r = RECIP_50;
      4'd3: r = RECIP_20;
      4'd4: r = RECIP_25;
      4'd5: r = mode ? RECIP_20 : RECIP_13;
      4'd6: r = mode ? RECIP_10 : RECIP_4;
      4'd7: r = RECIP_12;
      default: r = RECIP_100;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ucte_front.sv
module ucte_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ucte_pkg::in_t  in_data,
  output logic           ev_push,
  input  logic           ev_ready,
  output ucte_pkg::ev_t  ev_data
);
  import ucte_pkg::*;

  logic [1:0]  pc_r, pc_nxt;
  logic [2:0]  el_r, el_nxt;
  logic [7:0]  p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [2:0]  oth;
  logic        cls_en;
  logic [2:0]  cls;
  logic        handled;
  logic [20:0] cp;
  logic [7:0]  b;
  logic        fire;

  function automatic logic [2:0] classify(input logic [20:0] c);
    logic [2:0] k;
    if (c < 21'h80) begin
      if ((c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A)) k = CL_ALPHA;
      else if (c >= 21'h30 && c <= 21'h39) k = CL_DIGIT;
      else if (c == 21'h20 || c == 21'h09) k = CL_SPACE;
      else if (c == 21'h0A || c == 21'h0D) k = CL_NL;
      else k = CL_PUNCT;
    end else if (c >= 21'h1F000) begin
      k = CL_EMOJI;
    end else if ((c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF)
              || (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h20000 && c <= 21'h2A6DF)
              || (c >= 21'h2A700 && c <= 21'h2CEAF) || (c >= 21'hFF01 && c <= 21'hFF60)
              || (c >= 21'h3000 && c <= 21'h303F)) begin
      k = CL_CJK;
    end else begin
      k = CL_OTHER;
    end
    return k;
  endfunction

  assign b        = in_data.text_byte;
  assign in_ready = ev_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    pc_nxt  = pc_r;
    el_nxt  = el_r;
    p0_nxt  = p0_r;
    p1_nxt  = p1_r;
    p2_nxt  = p2_r;
    oth     = 3'd0;
    cls_en  = 1'b0;
    cls     = CL_OTHER;
    handled = 1'b0;
    cp      = 21'd0;
    if (in_data.byte_valid) begin
      if (pc_r != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          handled = 1'b1;
          if ({1'b0, pc_r} + 3'd1 >= el_r) begin
            unique case (el_r)
              3'd2: cp = {10'd0, p0_r[4:0], b[5:0]};
              3'd3: cp = {5'd0, p0_r[3:0], p1_r[5:0], b[5:0]};
              default: cp = {p0_r[2:0], p1_r[5:0], p2_r[5:0], b[5:0]};
            endcase
            cls_en = 1'b1;
            cls    = classify(cp);
            pc_nxt = 2'd0;
            el_nxt = 3'd0;
          end else begin
            if (pc_r == 2'd1) p1_nxt = b;
            else p2_nxt = b;
            pc_nxt = pc_r + 2'd1;
          end
        end else begin
          // broken sequence: held bytes go to other
          oth    = {1'b0, pc_r};
          pc_nxt = 2'd0;
          el_nxt = 3'd0;
        end
      end
      if (!handled) begin
        if (!b[7]) begin
          cls_en = 1'b1;
          cls    = classify({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
          el_nxt = 3'd2; p0_nxt = b; pc_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          el_nxt = 3'd3; p0_nxt = b; pc_nxt = 2'd1;
        end else if (b[7:3] == 5'b11110) begin
          el_nxt = 3'd4; p0_nxt = b; pc_nxt = 2'd1;
        end else begin
          oth = oth + 3'd1;
        end
      end
    end
    if (in_data.end_of_message) begin
      // unfinished sequence at message end
      oth    = oth + {1'b0, pc_nxt};
      pc_nxt = 2'd0;
      el_nxt = 3'd0;
    end
  end

  assign ev_data.oth_add = oth;
  assign ev_data.cls_en  = cls_en;
  assign ev_data.cls     = cls;
  assign ev_data.eom     = in_data.end_of_message;
  assign ev_data.eoc     = in_data.end_of_conversation;
  assign ev_push = fire && (oth != 3'd0 || cls_en || in_data.end_of_message);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 2'd0;
      el_r <= 3'd0;
      p0_r <= 8'd0;
      p1_r <= 8'd0;
      p2_r <= 8'd0;
    end else if (fire) begin
      pc_r <= pc_nxt;
      el_r <= el_nxt;
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

endmodule

FILE: rtl/ucte_queue.sv
module ucte_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          push_ready,
  input  ucte_pkg::ev_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output ucte_pkg::ev_t pop_data
);
  import ucte_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  ev_t                 mem_r [QDEPTH];
  logic [PTR_W-1:0]    wp_r, rp_r;
  logic [PTR_W:0]      cnt_r;
  logic                do_push, do_pop;

  assign push_ready = cnt_r != (PTR_W+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/ucte_back.sv
module ucte_back #(
  parameter int MAX_MESSAGE_BYTES = ucte_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ev_valid,
  output logic           ev_pop,
  input  ucte_pkg::ev_t  ev_data,
  input  logic           mode,
  input  logic [23:0]    limit,
  input  logic [6:0]     pct,
  output logic           out_valid,
  input  logic           out_ready,
  output ucte_pkg::out_t out_data
);
  import ucte_pkg::*;

  localparam int CAP_I = (MAX_MESSAGE_BYTES < CNT_MAX) ? MAX_MESSAGE_BYTES : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

  localparam logic [3:0] IDX_THR = 4'd8;
  localparam logic [3:0] IDX_FIN = 4'd9;
  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_QUO  = 2'd2;
  localparam logic [1:0] PH_FIX  = 2'd3;

  logic [CNT_W-1:0] cnt_r [NUM_CLASSES];
  logic             busy_r;
  logic [3:0]       idx_r;
  logic [1:0]       ph_r;
  logic [31:0]      n_r;
  logic [63:0]      p_r;
  logic [31:0]      q_r;
  logic [24:0]      sum_r;
  logic [23:0]      thr_r;
  logic             eoc_r;
  logic [31:0]      total_r;
  logic             out_valid_r;
  out_t             out_r;

  logic [6:0]       rate;
  logic [6:0]       pct_c;
  logic [32:0]      rem;
  logic [31:0]      quo;
  logic [25:0]      tok_w;
  logic [20:0]      tok;
  logic [32:0]      tot_w;
  logic [31:0]      tot;
  logic             fin_fire;

  assign ev_pop    = ev_valid && !busy_r;
  assign rate      = rate_of(idx_r, mode);
  assign pct_c     = (pct == 7'd0) ? 7'd1 : ((pct > 7'd100) ? 7'd100 : pct);
  assign rem       = {1'b0, n_r} - 33'(q_r * {25'd0, rate});
  assign quo       = (rem >= {26'd0, rate}) ? q_r + 32'd1 : q_r;
  assign tok_w     = {1'b0, sum_r} + 26'd4;
  assign tok       = (tok_w > 26'(CNT_MAX)) ? 21'(CNT_MAX) : tok_w[20:0];
  assign tot_w     = {1'b0, total_r} + {12'd0, tok};
  assign tot       = tot_w[32] ? 32'hFFFF_FFFF : tot_w[31:0];
  assign fin_fire  = busy_r && idx_r == IDX_FIN && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // counters: one request may add to other and to one class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) cnt_r[i] <= '0;
    end else if (fin_fire) begin
      for (int i = 0; i < NUM_CLASSES; i++) cnt_r[i] <= '0;
    end else if (ev_pop) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        logic [2:0]  add;
        logic [CNT_W:0] v;
        add = ((3'(i) == CL_OTHER) ? ev_data.oth_add : 3'd0)
            + {2'd0, (ev_data.cls_en && ev_data.cls == 3'(i))};
        v = {1'b0, cnt_r[i]} + {{(CNT_W-2){1'b0}}, add};
        cnt_r[i] <= (v > {1'b0, CAP}) ? CAP : v[CNT_W-1:0];
      end
    end
  end

  // estimate sequencer: eight class quotients then the threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 4'd0;
      ph_r        <= PH_LOAD;
      total_r     <= 32'd3;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (!busy_r) begin
        if (ev_pop && ev_data.eom) begin
          busy_r <= 1'b1;
          idx_r  <= 4'd0;
          ph_r   <= PH_LOAD;
          sum_r  <= '0;
          eoc_r  <= ev_data.eoc;
        end
      end else if (idx_r == IDX_FIN) begin
        if (fin_fire) begin
          out_r.message_tokens    <= tok;
          out_r.running_total     <= tot;
          out_r.compact_needed    <= tot >= {8'd0, thr_r};
          out_r.conversation_done <= eoc_r;
          out_valid_r             <= 1'b1;
          total_r                 <= eoc_r ? 32'd3 : tot;
          busy_r                  <= 1'b0;
        end
      end else begin
        unique case (ph_r)
          PH_LOAD: begin
            if (idx_r == IDX_THR) n_r <= {8'd0, limit} * {25'd0, pct_c};
            else n_r <= ({11'd0, cnt_r[idx_r[2:0]]} * 32'd10) + {26'd0, rate[6:1]};
            ph_r <= PH_MUL;
          end
          PH_MUL: begin
            p_r  <= n_r * recip_of(idx_r, mode);
            ph_r <= PH_QUO;
          end
          PH_QUO: begin
            q_r  <= p_r[63:32];
            ph_r <= PH_FIX;
          end
          PH_FIX: begin
            if (idx_r == IDX_THR) thr_r <= quo[23:0];
            else sum_r <= sum_r + quo[24:0];
            idx_r <= idx_r + 4'd1;
            ph_r  <= PH_LOAD;
          end
          default: ph_r <= PH_LOAD;
        endcase
      end
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ev_pop) else $error("request taken during estimate");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> out_valid_r && !busy_r && cnt_r[CL_OTHER] == '0)
    else $error("finish did not present result");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= IDX_FIN) else $error("sequencer index out of range");

endmodule

FILE: rtl/utf8_class_token_estimator.sv
// channel   dir   handshake               payload
// in_       in    in_valid / in_ready     in_data   (text byte and message marks)
// out_      out   out_valid / out_ready   out_data  (per-message estimate)
// cfg_      in    cfg_we                  cfg_index, cfg_wdata
//
// one byte per cycle enters while the queue has room; requests queue for counting
// an end-of-message request holds the counting side busy for eight class
// quotients and the threshold, each in load, multiply, quotient and fix
// steps through one reciprocal multiplier, then a finishing step that waits
// for the output register; the queue keeps taking bytes meanwhile until it fills
// synchronous active-low reset; total restarts at 3, counters at zero
module utf8_class_token_estimator #(
  parameter int MAX_MESSAGE_BYTES = ucte_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ucte_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ucte_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ucte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucte_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ucte_pkg::*;

  // configuration registers
  logic        mode_r;
  logic [23:0] limit_r;
  logic [6:0]  pct_r;

  // front to queue
  logic ev_push, ev_ready;
  ev_t  ev_in;
  // queue to back
  logic ev_valid, ev_pop;
  ev_t  ev_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      limit_r <= 24'd128000;
      pct_r   <= 7'd80;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        CFG_LIMIT: limit_r <= cfg_wdata;
        CFG_PCT:   pct_r   <= cfg_wdata[6:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // utf-8 decode and classify
  ucte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ev_push  (ev_push),
    .ev_ready (ev_ready),
    .ev_data  (ev_in)
  );

  // short request queue decoupling decode from counting
  ucte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_ready (ev_ready),
    .push_data  (ev_in),
    .pop_valid  (ev_valid),
    .pop        (ev_pop),
    .pop_data   (ev_out)
  );

  // class counters and end-of-message estimate
  ucte_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev_pop    (ev_pop),
    .ev_data   (ev_out),
    .mode      (mode_r),
    .limit     (limit_r),
    .pct       (pct_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
